[hw/rtl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

   localparam int unsigned CP_WIDTH = 21;

   // Byte class masks and codes
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] LEAD2_BITS  = 8'h1F;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD3_BITS  = 8'h0F;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_CODE  = 8'hF0;
   localparam logic [7:0] LEAD4_BITS  = 8'h07;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_CODE   = 8'h80;
   localparam logic [7:0] CONT_BITS   = 8'h3F;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP = 21'h00FFFD;

   // Continuation bytes still expected
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                is_replacement;
      logic                last_result;
   } rsp_type;

   typedef struct packed {
      logic                emit;
      rsp_type             rsp;
      logic [1:0]          pending_next;
      logic [CP_WIDTH-1:0] partial_next;
   } dec_out_type;

endpackage

[hw/rtl/u8d_decode.sv]
// Combinational decode of one byte against the current sequence state.
module u8d_decode
   import u8d_pkg::*;
(
   input  logic [1:0]          pending,
   input  logic [CP_WIDTH-1:0] partial,
   input  req_type             item,
   output dec_out_type         dec
);

   logic [7:0]          b;
   logic [1:0]          pend_dec;
   logic [CP_WIDTH-1:0] shifted;

   assign b        = item.text_byte;
   assign pend_dec = pending - 2'd1;
   assign shifted  = {partial[CP_WIDTH-7:0], b[5:0] & CONT_BITS[5:0]};

   always_comb begin
      dec.emit                = 1'b0;
      dec.rsp.code_point      = REPLACEMENT_CP;
      dec.rsp.is_replacement  = 1'b1;
      dec.rsp.last_result     = item.end_of_text;
      dec.pending_next        = pending;
      dec.partial_next        = partial;

      if (pending == PEND_NONE) begin
         priority if (b < ASCII_LIMIT) begin
            dec.emit               = 1'b1;
            dec.rsp.code_point     = {{(CP_WIDTH-8){1'b0}}, b};
            dec.rsp.is_replacement = 1'b0;
         end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            dec.pending_next = PEND_ONE;
            dec.partial_next = {{(CP_WIDTH-8){1'b0}}, b & LEAD2_BITS};
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            dec.pending_next = PEND_TWO;
            dec.partial_next = {{(CP_WIDTH-8){1'b0}}, b & LEAD3_BITS};
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            dec.pending_next = PEND_THREE;
            dec.partial_next = {{(CP_WIDTH-8){1'b0}}, b & LEAD4_BITS};
         end else begin
            // stray continuation or invalid lead; state stays clear
            dec.emit = 1'b1;
         end
         // a lead on the final byte is cut off at once
         if (item.end_of_text && dec.pending_next != PEND_NONE) begin
            dec.emit         = 1'b1;
            dec.pending_next = PEND_NONE;
            dec.partial_next = '0;
         end
      end else if ((b & CONT_MASK) != CONT_CODE) begin
         // bad continuation: byte consumed, sequence dropped
         dec.emit         = 1'b1;
         dec.pending_next = PEND_NONE;
         dec.partial_next = '0;
      end else if (pend_dec == PEND_NONE) begin
         dec.emit               = 1'b1;
         dec.rsp.code_point     = shifted;
         dec.rsp.is_replacement = 1'b0;
         dec.pending_next       = PEND_NONE;
         dec.partial_next       = '0;
      end else if (item.end_of_text) begin
         dec.emit         = 1'b1;
         dec.pending_next = PEND_NONE;
         dec.partial_next = '0;
      end else begin
         dec.pending_next = pend_dec;
         dec.partial_next = shifted;
      end
   end

endmodule

[hw/rtl/utf8_stream_decoder_top.sv]
// UTF-8 stream decoder: one byte in, zero or one code point out.
//
// Takes one byte per clock unless a held result stalls the input, and gives its
// code point, if any, on the result port through one input register, then the
// decode against the sequence state, then the result register. The sequence state
// (count of continuation bytes and partial code point) is updated in the same
// cycle that a byte leaves the input register, so a byte may be accepted on every
// cycle. A held result stalls the input only when the waiting byte itself
// produces a result. Errors give U+FFFD with is_replacement set; a byte
// flagged end_of_text always returns the sequence state to its reset value.
module utf8_stream_decoder_top
   import u8d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                in_valid_ff, in_valid_in;
   req_type             in_item_ff, in_item_in;
   logic [1:0]          pending_ff, pending_in;
   logic [CP_WIDTH-1:0] partial_ff, partial_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_item_ff, out_item_in;

   dec_out_type dec;
   logic        out_free;
   logic        advance;

   u8d_decode u_decode (
      .pending (pending_ff),
      .partial (partial_ff),
      .item    (in_item_ff),
      .dec     (dec)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   // an item with no result never waits on the output side
   assign advance   = in_valid_ff && (!dec.emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      pending_in   = pending_ff;
      partial_in   = partial_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         pending_in  = dec.pending_next;
         partial_in  = dec.partial_next;
         if (dec.emit) begin
            out_valid_in = 1'b1;
            out_item_in  = dec.rsp;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= PEND_NONE;
         partial_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pending_ff   <= pending_in;
         partial_ff   <= partial_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // end of text leaves no open sequence
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.end_of_text) |=> (pending_ff == PEND_NONE))
      else $error("sequence still open after final byte");

   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == PEND_NONE) |-> (partial_ff == '0))
      else $error("partial value left with no sequence open");

   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.is_replacement) |-> (out_item_ff.code_point == REPLACEMENT_CP))
      else $error("replacement flag without U+FFFD");

   // an item with a result must not be dropped while the output is stalled
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && dec.emit && out_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("item lost under output stall");

endmodule
